// ----- hdl/mtri_pkg.sv -----
// ----------------------------------------------------------------------------
// mtri_pkg
// Shared constants, types and the tempering function of the ranged MT19937.
// ----------------------------------------------------------------------------
`default_nettype none
package mtri_pkg;

	localparam int STATE_WORDS  = 624;
	localparam int TWIST_OFFSET = 397;
	localparam int IDX_W        = 10;
	localparam int WARMUP_DRAWS = 37;
	localparam int WARM_W       = 6;

	localparam logic [31:0] SEED_RESET   = 32'd4357;
	localparam logic [16:0] SEED_MULT    = 17'd69069;
	localparam logic [31:0] TWIST_MATRIX = 32'h9908b0df;
	localparam logic [31:0] UPPER_BIT    = 32'h80000000;
	localparam logic [31:0] LOWER_BITS   = 32'h7fffffff;
	localparam logic [31:0] TEMPER_B     = 32'h9d2c5680;
	localparam logic [31:0] TEMPER_C     = 32'hefc60000;

	typedef logic [IDX_W-1:0] idx_t;

	// commands from the top level to the word table
	typedef struct packed {
		logic draw;
		logic reseed;
	} tab_ctl_t;

	// status back from the word table
	typedef struct packed {
		logic busy;
		logic word_valid;
	} tab_sts_t;

	function automatic logic [31:0] temper(input logic [31:0] x);
		logic [31:0] y;
		y = x ^ (x >> 11);
		y = y ^ ((y << 7) & TEMPER_B);
		y = y ^ ((y << 15) & TEMPER_C);
		y = y ^ (y >> 18);
		return y;
	endfunction

endpackage
`default_nettype wire

// ----- hdl/mtri_table.sv -----
// ----------------------------------------------------------------------------
// mtri_table
// Word table in RAM: 69069 seeding, warm-up, one twisted and tempered word
// per draw.
// ----------------------------------------------------------------------------
`default_nettype none
module mtri_table (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire mtri_pkg::tab_ctl_t ctl,
	input  wire logic [31:0]       seed,
	output mtri_pkg::tab_sts_t     sts,
	output logic [31:0]            word
);

	localparam int IDX_W_P1 = mtri_pkg::IDX_W + 1;

	typedef enum logic [3:0] {
		T_IDLE = 4'b0001,
		T_FILL = 4'b0010,
		T_RD   = 4'b0100,
		T_WB   = 4'b1000
	} tstate_t;

	tstate_t                      state_q;
	mtri_pkg::idx_t               k_q;
	mtri_pkg::idx_t               idx_q;
	logic [31:0]                  prev_q;
	logic [31:0]                  cur_q;
	logic [mtri_pkg::WARM_W-1:0]  warm_q;
	logic [31:0]                  word_q;
	logic                         wvalid_q;

	logic [31:0] mem [mtri_pkg::STATE_WORDS];
	logic [31:0] rd_a, rd_b;

	logic                 we;
	mtri_pkg::idx_t       wa;
	logic [31:0]          wd;
	mtri_pkg::idx_t       nxt_idx, far_idx;
	logic [IDX_W_P1-1:0]  far_sum;
	logic [48:0]          prod;
	logic [31:0]          fill_val;
	logic [31:0]          y, twisted;

	always_comb begin
		nxt_idx = (idx_q == mtri_pkg::idx_t'(mtri_pkg::STATE_WORDS - 1)) ?
			'0 : idx_q + 1'b1;
		far_sum = {1'b0, idx_q} + IDX_W_P1'(mtri_pkg::TWIST_OFFSET);
		far_idx = (far_sum >= IDX_W_P1'(mtri_pkg::STATE_WORDS)) ?
			mtri_pkg::idx_t'(far_sum - IDX_W_P1'(mtri_pkg::STATE_WORDS)) :
			far_sum[mtri_pkg::IDX_W-1:0];
		prod     = prev_q * mtri_pkg::SEED_MULT;
		fill_val = (k_q == '0) ? prev_q : prod[31:0];
		y        = (cur_q & mtri_pkg::UPPER_BIT) | (rd_a & mtri_pkg::LOWER_BITS);
		twisted  = rd_b ^ (y >> 1) ^ (y[0] ? mtri_pkg::TWIST_MATRIX : 32'd0);
		we = 1'b0;
		wa = k_q;
		wd = fill_val;
		if (state_q == T_FILL) begin
			we = 1'b1;
		end else if (state_q == T_WB) begin
			we = 1'b1;
			wa = idx_q;
			wd = twisted;
		end
	end

	// two read ports, one write port, registered reads
	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		rd_a <= mem[nxt_idx];
		rd_b <= mem[far_idx];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= T_FILL;
			k_q      <= '0;
			prev_q   <= mtri_pkg::SEED_RESET;
			idx_q    <= '0;
			warm_q   <= '0;
			wvalid_q <= 1'b0;
		end else begin
			wvalid_q <= 1'b0;
			unique case (state_q)
				T_IDLE: begin
					if (ctl.reseed) begin
						prev_q  <= seed;
						k_q     <= '0;
						state_q <= T_FILL;
					end else if (ctl.draw) begin
						state_q <= T_RD;
					end
				end
				T_FILL: begin
					prev_q <= fill_val;
					if (k_q == mtri_pkg::idx_t'(mtri_pkg::STATE_WORDS - 1)) begin
						idx_q   <= '0;
						warm_q  <= mtri_pkg::WARM_W'(mtri_pkg::WARMUP_DRAWS);
						state_q <= T_RD;
					end else begin
						k_q <= k_q + 1'b1;
					end
				end
				T_RD: begin
					state_q <= T_WB;
				end
				T_WB: begin
					idx_q <= nxt_idx;
					if (warm_q != '0) begin
						warm_q  <= warm_q - 1'b1;
						state_q <= (warm_q == mtri_pkg::WARM_W'(1)) ? T_IDLE : T_RD;
					end else begin
						wvalid_q <= 1'b1;
						state_q  <= T_IDLE;
					end
				end
				default: state_q <= T_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == T_FILL && k_q == '0) begin
			cur_q <= fill_val;
		end else if (state_q == T_WB) begin
			cur_q <= rd_a;
		end
		if (state_q == T_WB) begin
			word_q <= mtri_pkg::temper(twisted);
		end
	end

	assign sts.busy       = (state_q != T_IDLE);
	assign sts.word_valid = wvalid_q;
	assign word           = word_q;

endmodule
`default_nettype wire

// ----- hdl/mtri_div.sv -----
// ----------------------------------------------------------------------------
// mtri_div
// Restoring divider, one quotient bit per cycle; returns the remainder.
// ----------------------------------------------------------------------------
`default_nettype none
module mtri_div (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [31:0] dividend,
	input  wire logic [31:0] divisor,
	output logic             done,
	output logic [31:0]      rem
);

	logic [31:0] rem_q, dvd_q, dsr_q;
	logic [5:0]  cnt_q;
	logic        busy_q, done_q;
	logic [32:0] trial;
	logic [31:0] rem_nxt;

	always_comb begin
		trial   = {rem_q, dvd_q[31]};
		rem_nxt = (trial >= {1'b0, dsr_q}) ? 32'(trial - {1'b0, dsr_q}) : trial[31:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd32;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvd_q <= dividend;
			dsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= rem_nxt;
			dvd_q <= dvd_q << 1;
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule
`default_nettype wire

// ----- hdl/mersenne_twister_ranged_int.sv -----
// ----------------------------------------------------------------------------
// mersenne_twister_ranged_int
// MT19937 source with raw 32-bit words and unbiased signed ranged integers.
// ----------------------------------------------------------------------------
// Usage:
//   Input item (in_valid/in_stall): op=0 asks for a raw tempered word,
//   op=1 for an integer in [range_lo, range_hi] (bounds in either order).
//   Output item (out_valid/out_stall): random_bits and ranged_value.
//   Seed: cfg_we with cfg_wdata reseeds the 624-word table; write only
//   while idle.
// Sequence:
//   raw or full-span draw: issue, table read, twist and write back, take
//   the word, load the output register; the next item is taken only once
//   that result is in the output register, so items do not overlap.
//   ranged draw: the bit-serial divider runs after each draw; a rejected
//   attempt repeats the draw (fewer than half of attempts reject).
//   equal bounds: no word is drawn; the result goes straight to the output
//   register.
// Reset and reseed:
//   the table is filled one word per cycle and then 37 draws are
//   discarded; no item is accepted while this runs.
// Stall:
//   one output register; a finished item waits there while the next item
//   is accepted and worked on, and the next result waits until it leaves.
// ----------------------------------------------------------------------------
`default_nettype none
module mersenne_twister_ranged_int (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        op,
	input  wire logic signed [31:0] range_lo,
	input  wire logic signed [31:0] range_hi,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [31:0]      random_bits,
	output logic signed [31:0] ranged_value,
	input  wire logic        cfg_we,
	input  wire logic [31:0] cfg_wdata
);

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_REQ  = 5'b00010,
		S_DRAW = 5'b00100,
		S_DIV  = 5'b01000,
		S_OUT  = 5'b10000
	} state_t;

	typedef enum logic [1:0] {
		M_RAW   = 2'd0,
		M_FULL  = 2'd1,
		M_RANGE = 2'd2
	} mode_t;

	state_t              state_q;
	mode_t               mode_q;
	logic [31:0]         lo_q, span_q, bits_q, value_q;
	logic                out_valid_q;
	logic [31:0]         out_bits_q, out_value_q;

	mtri_pkg::tab_ctl_t  ctl;
	mtri_pkg::tab_sts_t  sts;
	logic [31:0]         word;
	logic                div_start, div_done;
	logic [31:0]         div_rem;

	logic                accept, swap, accept_draw;
	logic [31:0]         a_lo, a_hi, a_span;
	logic [32:0]         accept_sum;
	logic                load_out;

	mtri_table u_table (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.seed   (cfg_wdata),
		.sts    (sts),
		.word   (word)
	);

	// divider starts in the cycle the word arrives, so it takes the word
	mtri_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (word),
		.divisor  (span_q),
		.done     (div_done),
		.rem      (div_rem)
	);

	always_comb begin
		accept   = in_valid && !in_stall;
		swap     = (range_lo > range_hi);
		a_lo     = swap ? range_hi : range_lo;
		a_hi     = swap ? range_lo : range_hi;
		a_span   = a_hi - a_lo + 32'd1;
		// accepted iff quotient < floor(2^32/span), i.e. bits - rem + span <= 2^32
		accept_sum  = {1'b0, bits_q} - {1'b0, div_rem} + {1'b0, span_q};
		accept_draw = (accept_sum <= 33'h1_0000_0000);
		ctl.draw    = (state_q == S_REQ);
		ctl.reseed  = cfg_we;
		div_start   = (state_q == S_DRAW) && sts.word_valid && (mode_q == M_RANGE);
		load_out    = (state_q == S_OUT) && (!out_valid_q || !out_stall);
	end

	assign in_stall = (state_q != S_IDLE) || sts.busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (op && range_lo == range_hi) begin
							state_q <= S_OUT;
						end else begin
							state_q <= S_REQ;
						end
					end
				end
				S_REQ: state_q <= S_DRAW;
				S_DRAW: begin
					if (sts.word_valid) begin
						state_q <= (mode_q == M_RANGE) ? S_DIV : S_OUT;
					end
				end
				S_DIV: begin
					if (div_done) begin
						state_q <= accept_draw ? S_OUT : S_REQ;
					end
				end
				S_OUT: begin
					if (load_out) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// item payload
	always_ff @(posedge clk) begin
		if (accept) begin
			lo_q    <= a_lo;
			span_q  <= a_span;
			bits_q  <= '0;
			value_q <= op ? range_lo : '0;
			if (!op) begin
				mode_q <= M_RAW;
			end else if (a_span == '0) begin
				mode_q <= M_FULL;
			end else begin
				mode_q <= M_RANGE;
			end
		end else if (state_q == S_DRAW && sts.word_valid) begin
			bits_q <= word;
			if (mode_q == M_FULL) begin
				value_q <= word + lo_q;
			end
		end else if (state_q == S_DIV && div_done) begin
			value_q <= div_rem + lo_q;
		end
		if (load_out) begin
			out_bits_q  <= bits_q;
			out_value_q <= value_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign random_bits  = out_bits_q;
	assign ranged_value = out_value_q;

	// remainder from the divider is always below the span
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV && div_done) |-> (div_rem < span_q))
		else $error("divider remainder not below span");

	// a ranged result is the lower bound plus the divider remainder, not below it
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV && div_done && accept_draw) |=>
		($signed(value_q) >= $signed(lo_q)) &&
		($signed(value_q - lo_q) == $signed($past(div_rem))))
		else $error("ranged value out of range");

	// a seed write puts the table into its refill
	assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_we && state_q == S_IDLE && !sts.busy) |=> sts.busy)
		else $error("reseed did not start table fill");

endmodule
`default_nettype wire

// ----- tb/mersenne_twister_ranged_int_tb.sv -----
// ----------------------------------------------------------------------------
// mersenne_twister_ranged_int_tb
// Self-checking bench for the ranged MT19937 source. A built-in model of the
// word table predicts every item; directed corner items are followed by
// random raw and ranged requests under several seeds and handshake loads.
// ----------------------------------------------------------------------------
`default_nettype none
module mersenne_twister_ranged_int_tb;

	localparam logic OP_RAW    = 1'b0;
	localparam logic OP_RANGED = 1'b1;
	localparam int   RUN_LIMIT = 1_500_000;
	localparam int   HOLD_LEN  = 3000;  // long receiver hold-off
	localparam int   DRAIN_GAP = 120;   // > one ranged attempt with rejects

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic op = OP_RAW;
	logic signed [31:0] range_lo = '0;
	logic signed [31:0] range_hi = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [31:0] random_bits;
	logic signed [31:0] ranged_value;
	logic cfg_we = 1'b0;
	logic [31:0] cfg_wdata = '0;

	always #5 clk = ~clk;

	mersenne_twister_ranged_int dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.op(op), .range_lo(range_lo), .range_hi(range_hi),
		.out_valid(out_valid), .out_stall(out_stall),
		.random_bits(random_bits), .ranged_value(ranged_value),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	// ---------------- model of the generator ----------------
	logic [31:0] mt_words [mtri_pkg::STATE_WORDS];
	int unsigned mt_pos;

	typedef struct {
		logic [31:0]        bits;
		logic signed [31:0] value;
	} draw_res_t;

	draw_res_t pending_q[$];
	int errors = 0;

	function automatic logic [31:0] next_tempered();
		logic [31:0] y;
		int unsigned nx, fr;
		if (mt_pos >= mtri_pkg::STATE_WORDS) begin
			// regenerate the whole table in place
			for (int k = 0; k < mtri_pkg::STATE_WORDS; k++) begin
				nx = (k + 1) % mtri_pkg::STATE_WORDS;
				fr = (k + mtri_pkg::TWIST_OFFSET) % mtri_pkg::STATE_WORDS;
				y = (mt_words[k] & mtri_pkg::UPPER_BIT) |
					(mt_words[nx] & mtri_pkg::LOWER_BITS);
				mt_words[k] = mt_words[fr] ^ (y >> 1) ^
					(y[0] ? mtri_pkg::TWIST_MATRIX : 32'h0);
			end
			mt_pos = 0;
		end
		y = mt_words[mt_pos];
		mt_pos++;
		y = y ^ (y >> 11);
		y = y ^ ((y << 7) & 32'h9d2c5680);
		y = y ^ ((y << 15) & 32'hefc60000);
		y = y ^ (y >> 18);
		return y;
	endfunction

	function automatic void reseed_model(input logic [31:0] s);
		mt_words[0] = s;
		for (int k = 1; k < mtri_pkg::STATE_WORDS; k++)
			mt_words[k] = mt_words[k-1] * 32'd69069;
		mt_pos = mtri_pkg::STATE_WORDS;
		for (int i = 0; i < mtri_pkg::WARMUP_DRAWS; i++)
			void'(next_tempered());
	endfunction

	function automatic draw_res_t predict_draw(input logic o,
			input logic [31:0] a, input logic [31:0] b);
		draw_res_t r;
		logic [31:0] lo, hi, span, lim;
		r.bits = '0;
		r.value = '0;
		lo = a;
		hi = b;
		if (o == OP_RAW) begin
			r.bits = next_tempered();
		end else if (lo == hi) begin
			r.value = lo;
		end else begin
			if ($signed(lo) > $signed(hi)) begin
				lo = b;
				hi = a;
			end
			span = hi - lo + 32'd1;
			if (span == 0) begin
				// full 32-bit span: raw word offset by lo
				r.bits = next_tempered();
				r.value = r.bits + lo;
			end else begin
				lim = 32'hffffffff / span;
				if (32'hffffffff % span == span - 32'd1)
					lim++;
				do
					r.bits = next_tempered();
				while (r.bits / span >= lim);   // reject biased tail
				r.value = (r.bits % span) + lo;
			end
		end
		return r;
	endfunction

	// ---------------- handshake load ----------------
	int send_idle_pct = 8;
	int recv_idle_pct = 45;
	bit hold_req = 0;
	int hold_left = 0;

	// receiver: random stall, plus one long hold-off on request
	always @(posedge clk) begin
		if (hold_req && hold_left == 0) begin
			hold_left = HOLD_LEN;
			hold_req = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	// result checker
	always @(posedge clk) begin
		draw_res_t e;
		if (out_valid && !out_stall) begin
			if (pending_q.size() == 0) begin
				$error("unexpected item: random_bits %h ranged_value %0d",
					random_bits, ranged_value);
				errors++;
			end else begin
				e = pending_q.pop_front();
				if (random_bits !== e.bits) begin
					$error("random_bits: expected %h, actual %h", e.bits, random_bits);
					errors++;
				end
				if (ranged_value !== e.value) begin
					$error("ranged_value: expected %0d, actual %0d", e.value,
						ranged_value);
					errors++;
				end
			end
		end
	end

	// watchdog
	int cycles = 0;
	always @(posedge clk) begin
		cycles++;
		if (cycles > RUN_LIMIT) begin
			$display("mersenne_twister_ranged_int_tb NOT OK");
			$finish;
		end
	end

	// ---------------- stimulus ----------------
	// Offer one item and hold it until taken; valid stays high afterwards so
	// back-to-back items need no extra edge. Known results go in as given.
	task automatic send_item(input logic o, input logic [31:0] a,
			input logic [31:0] b, input bit known, input draw_res_t k_res);
		draw_res_t r;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		op <= o;
		range_lo <= a;
		range_hi <= b;
		do @(posedge clk); while (in_stall);
		r = predict_draw(o, a, b);
		if (known)
			r = k_res;
		pending_q.push_back(r);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_GAP) @(posedge clk);
	endtask

	task automatic write_seed(input logic [31:0] s);
		cfg_we <= 1'b1;
		cfg_wdata <= s;
		@(posedge clk);
		cfg_we <= 1'b0;
		reseed_model(s);
	endtask

	// random item: mostly ranged requests with a spread of span shapes
	task automatic send_random();
		logic [31:0] a, b;
		logic o;
		int sel;
		draw_res_t none;
		none.bits = '0;
		none.value = '0;
		o = $urandom_range(2) != 0 ? OP_RANGED : OP_RAW;
		a = $urandom;
		b = $urandom;
		sel = $urandom_range(7);
		if (o == OP_RANGED) begin
			unique case (sel)
				0: b = a;                                   // equal bounds
				1: begin                                    // full span
					a = 32'h80000000;
					b = 32'h7fffffff;
					if ($urandom_range(1)) begin
						a = 32'h7fffffff;
						b = 32'h80000000;
					end
				end
				2, 3: b = a + $urandom_range(64) - 32;      // narrow range
				4: b = a + $urandom_range(32'h0000ffff);
				default: ;                                  // anything
			endcase
		end
		send_item(o, a, b, 0, none);
	endtask

	typedef struct {
		logic        op;
		logic [31:0] lo;
		logic [31:0] hi;
		bit          known;
		logic [31:0] bits;
		logic [31:0] value;
	} row_t;

	row_t corner_rows[] = '{
		'{OP_RAW,    32'h00000000, 32'h00000000, 0, 0, 0},
		'{OP_RAW,    32'hffffffff, 32'h80000000, 0, 0, 0},
		'{OP_RANGED, 32'h00000000, 32'h00000000, 1, 0, 32'h00000000},
		'{OP_RANGED, 32'h80000000, 32'h80000000, 1, 0, 32'h80000000},
		'{OP_RANGED, 32'h7fffffff, 32'h7fffffff, 1, 0, 32'h7fffffff},
		'{OP_RANGED, 32'hffffffff, 32'hffffffff, 1, 0, 32'hffffffff},
		'{OP_RANGED, 32'h00000000, 32'h00000001, 0, 0, 0},
		'{OP_RANGED, 32'h00000001, 32'h00000000, 0, 0, 0},
		'{OP_RANGED, 32'h80000000, 32'h7fffffff, 0, 0, 0},
		'{OP_RANGED, 32'h7fffffff, 32'h80000000, 0, 0, 0},
		'{OP_RANGED, 32'hffffffff, 32'h00000000, 0, 0, 0},
		'{OP_RANGED, 32'h80000000, 32'h80000001, 0, 0, 0},
		'{OP_RANGED, 32'h7ffffffe, 32'h7fffffff, 0, 0, 0},
		'{OP_RANGED, 32'h00000000, 32'h7fffffff, 0, 0, 0},  // span of exactly 2^31, no rejection
		'{OP_RANGED, 32'h80000000, 32'hffffffff, 0, 0, 0},
		'{OP_RANGED, 32'h80000000, 32'h00000000, 0, 0, 0},
		'{OP_RANGED, 32'hfffffffb, 32'h00000005, 0, 0, 0},
		'{OP_RAW,    32'h12345678, 32'h9abcdef0, 0, 0, 0}
	};

	initial begin
		draw_res_t k;
		reseed_model(mtri_pkg::SEED_RESET);
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// corner items on the reset seed
		foreach (corner_rows[i]) begin
			k.bits = corner_rows[i].bits;
			k.value = corner_rows[i].value;
			send_item(corner_rows[i].op, corner_rows[i].lo, corner_rows[i].hi,
				corner_rows[i].known, k);
		end
		drain();

		// phase 1: seed 0, sender rarely idle, receiver often stalls
		write_seed(32'h00000000);
		repeat (600) send_random();
		drain();

		// phase 2: all-ones seed, roles swapped, with a long hold-off so the
		// block backs up into its input
		send_idle_pct = 45;
		recv_idle_pct = 8;
		write_seed(32'hffffffff);
		hold_req = 1;
		repeat (650) send_random();
		drain();

		// phase 3: random seed, no idling at all
		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_seed($urandom);
		repeat (680) send_random();
		drain();

		if (errors == 0)
			$display("mersenne_twister_ranged_int_tb OK");
		else
			$display("mersenne_twister_ranged_int_tb NOT OK");
		$finish;
	end

endmodule
`default_nettype wire
